/* hdl/kohl_pkg.sv */
// kohl_pkg: sizes, codes and shared types of the key ordered handle list
// used by the channel interfaces, the cell chain and the top level
// no dependencies
package kohl_pkg;

  localparam int LIST_DEPTH     = 32;
  localparam int KEY_BITS       = 16;
  localparam int HANDLE_BITS    = 16;
  localparam int KEY_FIELD_BITS = 16;
  localparam int KIND_BITS      = 2;
  localparam int STATUS_BITS    = 2;
  localparam int POS_BITS       = 6;
  localparam int MAX_OUT        = 32;
  localparam int CNT_BITS       = $clog2(LIST_DEPTH + 1);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_CREATE  = 2'd0,
    KIND_DELETE  = 2'd1,
    KIND_REORDER = 2'd2,
    KIND_LIST    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // what every cell does in the current cycle
  typedef enum logic [1:0] {
    CH_HOLD = 2'd0,
    CH_INS  = 2'd1,
    CH_DEL  = 2'd2,
    CH_ROT  = 2'd3
  } chain_op_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [KEY_BITS-1:0]    key;
  } entry_t;

  // broadcast to all cells
  typedef struct packed {
    chain_op_t op;
    entry_t    ent;
  } chain_ctl_t;

  // where a cell sits relative to the fill level
  typedef struct packed {
    logic occupied;
    logic tail;
    logic at_fill;
  } cell_pos_t;

  function automatic logic [POS_BITS-1:0] fit_pos(input logic [CNT_BITS-1:0] v);
    logic [CNT_BITS+POS_BITS-1:0] t;
    t = {{POS_BITS{1'b0}}, v};
    return t[POS_BITS-1:0];
  endfunction

  function automatic logic [KEY_FIELD_BITS-1:0] key_to_field(input logic [KEY_BITS-1:0] v);
    logic [KEY_BITS+KEY_FIELD_BITS-1:0] t;
    t = {{KEY_FIELD_BITS{1'b0}}, v};
    return t[KEY_FIELD_BITS-1:0];
  endfunction

  function automatic logic [KEY_BITS-1:0] field_to_key(input logic [KEY_FIELD_BITS-1:0] v);
    logic [KEY_BITS+KEY_FIELD_BITS-1:0] t;
    t = {{KEY_BITS{1'b0}}, v};
    return t[KEY_BITS-1:0];
  endfunction

endpackage

/* hdl/kohl_cmd_if.sv */
// kohl_cmd_if: command channel of the key ordered handle list
// valid/ready handshake with kind, handle and new_key; uses kohl_pkg
interface kohl_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [kohl_pkg::KIND_BITS-1:0]      kind;
  logic [kohl_pkg::HANDLE_BITS-1:0]    handle;
  logic [kohl_pkg::KEY_FIELD_BITS-1:0] new_key;

  modport source (output valid, kind, handle, new_key, input ready);
  modport sink   (input valid, kind, handle, new_key, output ready);
endinterface

/* hdl/kohl_rsp_if.sv */
// kohl_rsp_if: result channel of the key ordered handle list
// valid/ready handshake with status, handle, key, position, count, last; uses kohl_pkg
interface kohl_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [kohl_pkg::STATUS_BITS-1:0]    status;
  logic [kohl_pkg::HANDLE_BITS-1:0]    out_handle;
  logic [kohl_pkg::KEY_FIELD_BITS-1:0] out_key;
  logic [kohl_pkg::POS_BITS-1:0]       position;
  logic [kohl_pkg::POS_BITS-1:0]       entry_count;
  logic                                last;

  modport source (output valid, status, out_handle, out_key, position, entry_count, last,
                  input ready);
  modport sink   (input valid, status, out_handle, out_key, position, entry_count, last,
                  output ready);
endinterface

/* hdl/kohl_cell.sv */
// kohl_cell: one slot of the sorted list, holds a handle and its key
// shifts right on insert, left on delete, rotates for listing; uses kohl_pkg
module kohl_cell (
  input  logic                 clk,
  input  kohl_pkg::chain_ctl_t ctl,
  input  kohl_pkg::cell_pos_t  pos,
  input  kohl_pkg::entry_t     left_ent,
  input  kohl_pkg::entry_t     right_ent,
  input  kohl_pkg::entry_t     head_ent,
  input  logic                 g_left,
  input  logic                 seen_left,
  output kohl_pkg::entry_t     ent,
  output logic                 g,
  output logic                 seen,
  output logic                 ins_here,
  output logic                 del_here
);

  logic match;

  // empty slots count as greater so the insert boundary is the first set bit
  assign match    = pos.occupied && (ent.handle == ctl.ent.handle);
  assign g        = !pos.occupied || (ent.key > ctl.ent.key);
  assign seen     = seen_left || match;
  assign del_here = match && !seen_left;
  assign ins_here = (pos.occupied || pos.at_fill) && g && !g_left;

  always_ff @(posedge clk) begin
    case (ctl.op)
      kohl_pkg::CH_INS: begin
        if ((pos.occupied || pos.at_fill) && g) begin
          ent <= g_left ? left_ent : ctl.ent;
        end
      end
      kohl_pkg::CH_DEL: begin
        if (pos.occupied && seen) begin
          ent <= right_ent;
        end
      end
      kohl_pkg::CH_ROT: begin
        if (pos.occupied) begin
          ent <= pos.tail ? head_ent : right_ent;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/kohl_chain.sv */
// kohl_chain: row of kohl_cell slots with neighbor links and position encoders
// reports insert place, first handle match and the head entry; uses kohl_pkg, kohl_cell
module kohl_chain (
  input  logic                          clk,
  input  kohl_pkg::chain_ctl_t          ctl,
  input  logic [kohl_pkg::CNT_BITS-1:0] fill,
  output logic [kohl_pkg::CNT_BITS-1:0] ins_pos,
  output logic [kohl_pkg::CNT_BITS-1:0] del_pos,
  output logic [kohl_pkg::KEY_BITS-1:0] del_key,
  output logic                          found,
  output kohl_pkg::entry_t              head
);

  kohl_pkg::entry_t    ents [kohl_pkg::LIST_DEPTH];
  kohl_pkg::cell_pos_t cpos [kohl_pkg::LIST_DEPTH];
  logic [kohl_pkg::LIST_DEPTH-1:0] g_v;
  logic [kohl_pkg::LIST_DEPTH-1:0] seen_v;
  logic [kohl_pkg::LIST_DEPTH-1:0] ins_v;
  logic [kohl_pkg::LIST_DEPTH-1:0] del_v;

  for (genvar i = 0; i < kohl_pkg::LIST_DEPTH; i++) begin : g_cell
    kohl_pkg::entry_t left_ent;
    kohl_pkg::entry_t right_ent;
    logic             g_left;
    logic             seen_left;

    assign cpos[i] = '{occupied: (kohl_pkg::CNT_BITS'(i) <  fill),
                       tail:     (kohl_pkg::CNT_BITS'(i) == fill - 1'b1),
                       at_fill:  (kohl_pkg::CNT_BITS'(i) == fill)};

    if (i == 0) begin : g_first
      assign left_ent  = ctl.ent;
      assign g_left    = 1'b0;
      assign seen_left = 1'b0;
    end else begin : g_mid
      assign left_ent  = ents[i-1];
      assign g_left    = g_v[i-1];
      assign seen_left = seen_v[i-1];
    end

    if (i == kohl_pkg::LIST_DEPTH - 1) begin : g_end
      assign right_ent = ents[0];
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    kohl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (cpos[i]),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .head_ent  (ents[0]),
      .g_left    (g_left),
      .seen_left (seen_left),
      .ent       (ents[i]),
      .g         (g_v[i]),
      .seen      (seen_v[i]),
      .ins_here  (ins_v[i]),
      .del_here  (del_v[i])
    );
  end

  // one-hot to binary, and the key of the single matching slot
  always_comb begin
    ins_pos = '0;
    del_pos = '0;
    del_key = '0;
    for (int i = 0; i < kohl_pkg::LIST_DEPTH; i++) begin
      ins_pos = ins_pos | (ins_v[i] ? kohl_pkg::CNT_BITS'(i) : '0);
      del_pos = del_pos | (del_v[i] ? kohl_pkg::CNT_BITS'(i) : '0);
      del_key = del_key | (del_v[i] ? ents[i].key : '0);
    end
  end

  assign found = seen_v[kohl_pkg::LIST_DEPTH-1];
  assign head  = ents[0];

endmodule

/* hdl/key_ordered_handle_list_top.sv */
// key_ordered_handle_list_top: sorted handle list with create, delete, reorder, list
// depends on kohl_pkg, kohl_cmd_if, kohl_rsp_if, kohl_chain
//
//   port  dir  carries
//   ----  ---  -----------------------------------------------------------
//   cmd   in   kind, handle, new_key
//   rsp   out  status, out_handle, out_key, position, entry_count, last
//
// create runs S_INS, delete S_DEL, reorder S_DEL then S_INS, list S_LIST; one
//   command at a time, since every command changes or walks the whole cell row
// list rotates the row once per cycle while rsp_free holds, slot 0 feeds the result
// reset (rst, synchronous) empties the list and clears the key counter
// a full result register holds the sequencer until rsp takes the item;
//   cmd is taken again as soon as the last result sits in that register
module key_ordered_handle_list_top (
  input  logic           clk,
  input  logic           rst,
  kohl_cmd_if.sink       cmd,
  kohl_rsp_if.source     rsp
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEL  = 4'b0010,
    S_INS  = 4'b0100,
    S_LIST = 4'b1000
  } state_t;

  state_t state, state_next;

  // command held for the sequencer
  kohl_pkg::kind_t                  op_kind;
  logic [kohl_pkg::HANDLE_BITS-1:0] op_handle;
  logic [kohl_pkg::KEY_BITS-1:0]    op_key;

  logic [kohl_pkg::CNT_BITS-1:0] fill, fill_next;
  logic [kohl_pkg::KEY_BITS-1:0] next_key;
  logic [kohl_pkg::CNT_BITS-1:0] cnt;

  // result register
  logic                                rsp_valid;
  logic [kohl_pkg::STATUS_BITS-1:0]    rsp_status;
  logic [kohl_pkg::HANDLE_BITS-1:0]    rsp_handle;
  logic [kohl_pkg::KEY_FIELD_BITS-1:0] rsp_key;
  logic [kohl_pkg::POS_BITS-1:0]       rsp_pos;
  logic [kohl_pkg::POS_BITS-1:0]       rsp_count;
  logic                                rsp_last;

  logic                                ld;
  logic [kohl_pkg::STATUS_BITS-1:0]    status_next;
  logic [kohl_pkg::HANDLE_BITS-1:0]    handle_next;
  logic [kohl_pkg::KEY_FIELD_BITS-1:0] key_next;
  logic [kohl_pkg::POS_BITS-1:0]       pos_next;
  logic [kohl_pkg::POS_BITS-1:0]       count_next;
  logic                                last_next;

  // chain side
  kohl_pkg::chain_ctl_t          ctl;
  logic [kohl_pkg::CNT_BITS-1:0] ins_pos;
  logic [kohl_pkg::CNT_BITS-1:0] del_pos;
  logic [kohl_pkg::KEY_BITS-1:0] del_key;
  logic                          found;
  kohl_pkg::entry_t              head;

  logic cmd_fire;
  logic rsp_free;
  logic full;
  logic list_emit;
  logic list_last;
  logic list_step;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign rsp_free  = !rsp_valid || rsp.ready;
  assign full      = (fill == kohl_pkg::CNT_BITS'(kohl_pkg::LIST_DEPTH));

  // list results stop after MAX_OUT, the rotation still runs to the end
  assign list_emit = int'(cnt) < kohl_pkg::MAX_OUT;
  assign list_last = (cnt == fill - 1'b1);
  assign list_step = (state == S_LIST) && (!list_emit || rsp_free);

  kohl_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .fill    (fill),
    .ins_pos (ins_pos),
    .del_pos (del_pos),
    .del_key (del_key),
    .found   (found),
    .head    (head)
  );

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    ctl.op         = kohl_pkg::CH_HOLD;
    ctl.ent.handle = op_handle;
    ctl.ent.key    = op_key;
    ld             = 1'b0;
    status_next    = kohl_pkg::ST_DONE;
    handle_next    = op_handle;
    key_next       = kohl_pkg::key_to_field(op_key);
    pos_next       = '0;
    count_next     = kohl_pkg::fit_pos(fill);
    last_next      = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          case (cmd.kind)
            kohl_pkg::KIND_CREATE:  state_next = S_INS;
            kohl_pkg::KIND_DELETE:  state_next = S_DEL;
            kohl_pkg::KIND_REORDER: state_next = S_DEL;
            kohl_pkg::KIND_LIST:    state_next = (fill != '0) ? S_LIST : S_IDLE;
            default:                state_next = S_IDLE;
          endcase
        end
      end
      S_DEL: begin
        if (op_kind == kohl_pkg::KIND_REORDER) begin
          // silent removal ahead of the re-insert
          ctl.op     = kohl_pkg::CH_DEL;
          fill_next  = found ? fill - 1'b1 : fill;
          state_next = S_INS;
        end else if (rsp_free) begin
          ctl.op     = kohl_pkg::CH_DEL;
          ld         = 1'b1;
          state_next = S_IDLE;
          if (found) begin
            fill_next  = fill - 1'b1;
            key_next   = kohl_pkg::key_to_field(del_key);
            pos_next   = kohl_pkg::fit_pos(del_pos);
            count_next = kohl_pkg::fit_pos(fill - 1'b1);
          end else begin
            status_next = kohl_pkg::ST_NOT_FOUND;
            key_next    = '0;
          end
        end
      end
      S_INS: begin
        if (rsp_free) begin
          ld         = 1'b1;
          state_next = S_IDLE;
          if (!full) begin
            ctl.op     = kohl_pkg::CH_INS;
            fill_next  = fill + 1'b1;
            pos_next   = kohl_pkg::fit_pos(ins_pos);
            count_next = kohl_pkg::fit_pos(fill + 1'b1);
          end else begin
            status_next = kohl_pkg::ST_FULL;
          end
        end
      end
      S_LIST: begin
        if (list_step) begin
          ctl.op      = kohl_pkg::CH_ROT;
          ld          = list_emit;
          handle_next = head.handle;
          key_next    = kohl_pkg::key_to_field(head.key);
          pos_next    = kohl_pkg::fit_pos(cnt);
          last_next   = list_last || (int'(cnt) == kohl_pkg::MAX_OUT - 1);
          if (list_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      next_key  <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      // key counter saturates at its top value
      if (cmd_fire && (cmd.kind == kohl_pkg::KIND_CREATE) && (next_key != '1)) begin
        next_key <= next_key + 1'b1;
      end
      if (cmd_fire) begin
        cnt <= '0;
      end else if (list_step) begin
        cnt <= cnt + 1'b1;
      end
      if (ld) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      op_kind   <= kohl_pkg::kind_t'(cmd.kind);
      op_handle <= cmd.handle;
      op_key    <= (cmd.kind == kohl_pkg::KIND_CREATE) ? next_key
                                                        : kohl_pkg::field_to_key(cmd.new_key);
    end
    if (ld) begin
      rsp_status <= status_next;
      rsp_handle <= handle_next;
      rsp_key    <= key_next;
      rsp_pos    <= pos_next;
      rsp_count  <= count_next;
      rsp_last   <= last_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.out_handle  = rsp_handle;
  assign rsp.out_key     = rsp_key;
  assign rsp.position    = rsp_pos;
  assign rsp.entry_count = rsp_count;
  assign rsp.last        = rsp_last;

  // fill level never passes the row length
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= kohl_pkg::CNT_BITS'(kohl_pkg::LIST_DEPTH))
    else $error("fill level beyond list depth");

  // insert lands inside the occupied range or just past it
  a_ins_place: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == kohl_pkg::CH_INS) |-> (ins_pos <= fill) && !full)
    else $error("insert place outside list");

  // a removed slot is an occupied one
  a_del_place: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == kohl_pkg::CH_DEL && found) |-> (del_pos < fill))
    else $error("delete place outside list");

  // listing leaves the fill level alone
  a_list_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST && !rst) |=> (fill == $past(fill)))
    else $error("fill level changed while listing");

  // a new result only enters a free result register
  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    ld |-> rsp_free)
    else $error("result register overwritten");

endmodule
